FILE: rtl/gvf_pkg.sv
// shared constants, types and helpers for the garch variance filter
package gvf_pkg;

  localparam int RET_W    = 32;
  localparam int VAR_W    = 48;
  localparam int SIGMA_W  = 24;
  localparam int STAT_W   = 2;
  localparam int AB_W     = 17;
  localparam int W_W      = 16;
  localparam int ACC_W    = VAR_W + 2;
  localparam int MUL_A_W  = VAR_W - W_W;
  localparam int MUL_B_W  = AB_W;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int OMEGA_HI_W = VAR_W - 32;

  localparam logic [AB_W-1:0]  MAX_PERSIST = AB_W'(65470);
  localparam logic [AB_W-1:0]  ONE_Q16     = AB_W'(65536);
  localparam logic [VAR_W-1:0] VMAX        = {VAR_W{1'b1}};

  localparam int DIV_STEPS  = VAR_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int SQRT_STEPS = SIGMA_W;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
  localparam int SQRT_REM_W = SIGMA_W + 2;

  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;

  localparam logic [2:0] REG_OMEGA     = 3'd0;
  localparam logic [2:0] REG_ALPHA     = 3'd1;
  localparam logic [2:0] REG_BETA      = 3'd2;
  localparam logic [2:0] REG_SEED_MODE = 3'd3;
  localparam logic [2:0] REG_SEED_VAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVF     = 2'd2;

  typedef struct packed {
    logic               load;
    logic [ACC_W-1:0]   load_val;
    logic               mul;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
    logic               shift;
  } mac_cmd_t;

  typedef struct packed {
    logic             ov;
    logic [VAR_W-1:0] val;
  } sat_t;

  function automatic sat_t sat_var(input logic [ACC_W-1:0] x);
    sat_t s;
    if (x > {2'b00, VMAX}) begin
      s.ov  = 1'b1;
      s.val = VMAX;
    end else begin
      s.ov  = 1'b0;
      s.val = x[VAR_W-1:0];
    end
    return s;
  endfunction

endpackage

FILE: rtl/gvf_mac.sv
// shared multiplier with registered product and accumulator
module gvf_mac (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gvf_pkg::mac_cmd_t       cmd,
  output logic [gvf_pkg::ACC_W-1:0] acc
);
  import gvf_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic              shift_r;
  logic              add_pend_r;
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  addend;

  assign addend = shift_r ? ACC_W'(prod_r >> W_W) : ACC_W'(prod_r);
  assign acc    = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_pend_r <= 1'b0;
    end else begin
      add_pend_r <= cmd.mul;
    end
    prod_r  <= PROD_W'(cmd.a) * PROD_W'(cmd.b);
    shift_r <= cmd.shift;
    if (cmd.load) begin
      acc_r <= cmd.load_val;
    end else if (add_pend_r) begin
      acc_r <= acc_r + addend;
    end
  end

endmodule

FILE: rtl/gvf_div.sv
// bit-serial restoring divider for the unconditional variance
module gvf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [gvf_pkg::OMEGA_HI_W-1:0] rem_init,
  input  logic [31:0]                   dividend_lo,
  input  logic [gvf_pkg::AB_W-1:0]      divisor,
  output logic                          busy,
  output logic [gvf_pkg::VAR_W-1:0]     quotient
);
  import gvf_pkg::*;

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [AB_W-1:0]      rem_r;
  logic [AB_W-1:0]      div_r;
  logic [VAR_W-1:0]     data_r;
  logic [AB_W:0]        trial;
  logic                 ge;
  logic [AB_W:0]        diff;

  assign trial    = {rem_r, data_r[VAR_W-1]};
  assign ge       = trial >= {1'b0, div_r};
  assign diff     = trial - {1'b0, div_r};
  assign busy     = busy_r;
  assign quotient = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
    if (start) begin
      rem_r  <= {1'b0, rem_init};
      data_r <= {dividend_lo, {(VAR_W-32){1'b0}}};
      div_r  <= divisor;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[AB_W-1:0] : trial[AB_W-1:0];
      data_r <= {data_r[VAR_W-2:0], ge};
    end
  end

endmodule

FILE: rtl/gvf_sqrt.sv
// bit-serial integer square root, one result bit per cycle
module gvf_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [gvf_pkg::VAR_W-1:0]   radicand,
  output logic                        busy,
  output logic [gvf_pkg::SIGMA_W-1:0] root
);
  import gvf_pkg::*;

  logic                  busy_r;
  logic [SQRT_CNT_W-1:0] cnt_r;
  logic [VAR_W-1:0]      rad_r;
  logic [SQRT_REM_W-1:0] rem_r;
  logic [SIGMA_W-1:0]    root_r;
  logic [SQRT_REM_W+1:0] cur;
  logic [SQRT_REM_W+1:0] trial;
  logic                  ge;
  logic [SQRT_REM_W+1:0] diff;

  assign cur   = {rem_r, rad_r[VAR_W-1 -: 2]};
  assign trial = (SQRT_REM_W+2)'({root_r, 2'b01});
  assign ge    = cur >= trial;
  assign diff  = cur - trial;
  assign busy  = busy_r;
  assign root  = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= SQRT_CNT_W'(SQRT_STEPS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[VAR_W-3:0], 2'b00};
      rem_r  <= ge ? diff[SQRT_REM_W-1:0] : cur[SQRT_REM_W-1:0];
      root_r <= {root_r[SIGMA_W-2:0], ge};
    end
  end

endmodule

FILE: rtl/garch_variance_filter_core.sv
// garch(1,1) variance filter top level: config port, sequencer, result register
// a seeded series goes through S_RUN, the square and update states, then S_FIN and S_WAIT;
//   seeding from a backcast adds S_SEED0 to S_SEEDFIN, the unconditional variance also S_DIV
// invalid parameters skip seeding and the root and go straight from S_IDLE to S_WAIT
// a new item is taken only in S_IDLE, after the last result; the 24-step square root sets the pace
// reset: synchronous active low, clears registers, variance, seeded and overflow status
module garch_variance_filter_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [gvf_pkg::RET_W-1:0]    in_tdata,   // return_value
  input  logic [1:0]                   in_tuser,   // missing, restart
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [gvf_pkg::SIGMA_W-1:0]  out_tdata,  // sigma
  output logic [gvf_pkg::STAT_W-1:0]   out_tuser,  // status
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [gvf_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [gvf_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [gvf_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import gvf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_SEED0, S_SEED1, S_SEED2, S_SEEDFIN, S_RUN,
    S_SQ0, S_SQ1, S_SQ2, S_UA0, S_UA1, S_UA2, S_UB0, S_UB1, S_UB2,
    S_FIN, S_WAIT
  } state_t;

  state_t state_r;

  logic [VAR_W-1:0] omega_r;
  logic [W_W-1:0]   alpha_r;
  logic [W_W-1:0]   beta_r;
  logic             seed_mode_r;
  logic [VAR_W-1:0] seed_var_r;

  logic [VAR_W-1:0]   variance_r;
  logic               overflowed_r;
  logic               seeded_r;
  logic [RET_W-1:0]   mag_r;
  logic               missing_r;
  logic               inv_r;
  logic               seed_ov_r;
  logic               upd_ov_r;
  logic [VAR_W-1:0]   bc_r;
  logic [VAR_W-1:0]   r2_r;
  logic [STAT_W-1:0]  stat_r;
  logic               out_tvalid_r;
  logic [SIGMA_W-1:0] sigma_r;
  logic [STAT_W-1:0]  status_r;

  logic [AB_W-1:0]  ab;
  logic [AB_W-1:0]  denom;
  logic             invalid;
  logic             cfg_wr;
  logic             in_acc;
  logic [RET_W-1:0] mag_in;
  logic [VAR_W-1:0] r2_now;
  logic             div_start;
  logic             div_busy;
  logic [VAR_W-1:0] div_q;
  logic             sqrt_start;
  logic             sqrt_busy;
  logic [SIGMA_W-1:0] sqrt_root;
  logic             res_ready;
  mac_cmd_t         mac_cmd;
  logic [ACC_W-1:0] mac_acc;
  sat_t             sat_now;

  assign ab       = {1'b0, alpha_r} + {1'b0, beta_r};
  assign denom    = ONE_Q16 - ab;
  assign invalid  = (omega_r == '0) || (ab >= MAX_PERSIST) ||
                    (seed_mode_r && (seed_var_r == '0));
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign mag_in     = in_tdata[RET_W-1] ? RET_W'(~in_tdata + 1'b1) : in_tdata;
  assign r2_now     = missing_r ? variance_r : mac_acc[VAR_W-1:0];
  assign sat_now    = sat_var(mac_acc);
  assign div_start  = in_acc && !invalid && (in_tuser[1] || !seeded_r) && !seed_mode_r &&
                      (seed_var_r == '0) && ({1'b0, omega_r[VAR_W-1:32]} < denom);
  assign sqrt_start = (state_r == S_RUN);
  assign res_ready  = (inv_r || !sqrt_busy) && (!out_tvalid_r || out_tready);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = sigma_r;
  assign out_tuser  = status_r;

  always_comb begin
    unique case (cfg_paddr[5:3])
      REG_OMEGA:     cfg_prdata = CFG_DW'(omega_r);
      REG_ALPHA:     cfg_prdata = CFG_DW'(alpha_r);
      REG_BETA:      cfg_prdata = CFG_DW'(beta_r);
      REG_SEED_MODE: cfg_prdata = CFG_DW'(seed_mode_r);
      REG_SEED_VAR:  cfg_prdata = CFG_DW'(seed_var_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_comb begin
    mac_cmd = '0;
    unique case (state_r)
      S_SEED0: begin
        mac_cmd.load     = 1'b1;
        mac_cmd.load_val = {2'b00, omega_r};
        mac_cmd.mul      = 1'b1;
        mac_cmd.a        = bc_r[VAR_W-1:W_W];
        mac_cmd.b        = ab;
      end
      S_SEED1: begin
        mac_cmd.mul   = 1'b1;
        mac_cmd.a     = MUL_A_W'(bc_r[W_W-1:0]);
        mac_cmd.b     = ab;
        mac_cmd.shift = 1'b1;
      end
      S_SQ0: begin
        mac_cmd.load = 1'b1;
        mac_cmd.mul  = 1'b1;
        mac_cmd.a    = mag_r;
        mac_cmd.b    = MUL_B_W'(mag_r[RET_W-1:W_W]);
      end
      S_SQ1: begin
        mac_cmd.mul   = 1'b1;
        mac_cmd.a     = mag_r;
        mac_cmd.b     = MUL_B_W'(mag_r[W_W-1:0]);
        mac_cmd.shift = 1'b1;
      end
      S_UA0: begin
        mac_cmd.load     = 1'b1;
        mac_cmd.load_val = {2'b00, omega_r};
        mac_cmd.mul      = 1'b1;
        mac_cmd.a        = r2_now[VAR_W-1:W_W];
        mac_cmd.b        = MUL_B_W'(alpha_r);
      end
      S_UA1: begin
        mac_cmd.mul   = 1'b1;
        mac_cmd.a     = MUL_A_W'(r2_r[W_W-1:0]);
        mac_cmd.b     = MUL_B_W'(alpha_r);
        mac_cmd.shift = 1'b1;
      end
      S_UB0: begin
        mac_cmd.load     = 1'b1;
        mac_cmd.load_val = {2'b00, sat_now.val};
        mac_cmd.mul      = 1'b1;
        mac_cmd.a        = variance_r[VAR_W-1:W_W];
        mac_cmd.b        = MUL_B_W'(beta_r);
      end
      S_UB1: begin
        mac_cmd.mul   = 1'b1;
        mac_cmd.a     = MUL_A_W'(variance_r[W_W-1:0]);
        mac_cmd.b     = MUL_B_W'(beta_r);
        mac_cmd.shift = 1'b1;
      end
      default: mac_cmd = '0;
    endcase
  end

  gvf_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mac_cmd),
    .acc   (mac_acc)
  );

  gvf_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (div_start),
    .rem_init    (omega_r[VAR_W-1:32]),
    .dividend_lo (omega_r[31:0]),
    .divisor     (denom),
    .busy        (div_busy),
    .quotient    (div_q)
  );

  gvf_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (variance_r),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      omega_r      <= '0;
      alpha_r      <= '0;
      beta_r       <= '0;
      seed_mode_r  <= 1'b0;
      seed_var_r   <= '0;
      variance_r   <= '0;
      overflowed_r <= 1'b0;
      seeded_r     <= 1'b0;
      inv_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_paddr[5:3])
          REG_OMEGA:     omega_r     <= cfg_pwdata[VAR_W-1:0];
          REG_ALPHA:     alpha_r     <= cfg_pwdata[W_W-1:0];
          REG_BETA:      beta_r      <= cfg_pwdata[W_W-1:0];
          REG_SEED_MODE: seed_mode_r <= cfg_pwdata[0];
          REG_SEED_VAR:  seed_var_r  <= cfg_pwdata[VAR_W-1:0];
          default: ;
        endcase
      end
      if ((state_r == S_WAIT) && res_ready) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            mag_r     <= mag_in;
            missing_r <= in_tuser[0];
            seed_ov_r <= 1'b0;
            if (invalid) begin
              variance_r   <= '0;
              seeded_r     <= 1'b0;
              overflowed_r <= 1'b0;
              inv_r        <= 1'b1;
              stat_r       <= ST_INVALID;
              state_r      <= S_WAIT;
            end else begin
              inv_r <= 1'b0;
              if (in_tuser[1] || !seeded_r) begin
                seeded_r <= 1'b1;
                if (seed_mode_r) begin
                  variance_r   <= seed_var_r;
                  overflowed_r <= 1'b0;
                  state_r      <= S_RUN;
                end else if (seed_var_r != '0) begin
                  bc_r    <= seed_var_r;
                  state_r <= S_SEED0;
                end else if (div_start) begin
                  state_r <= S_DIV;
                end else begin
                  bc_r      <= VMAX;
                  seed_ov_r <= 1'b1;
                  state_r   <= S_SEED0;
                end
              end else begin
                state_r <= S_RUN;
              end
            end
          end
        end
        S_DIV: begin
          if (!div_busy) begin
            bc_r    <= div_q;
            state_r <= S_SEED0;
          end
        end
        S_SEED0:   state_r <= S_SEED1;
        S_SEED1:   state_r <= S_SEED2;
        S_SEED2:   state_r <= S_SEEDFIN;
        S_SEEDFIN: begin
          variance_r   <= sat_now.val;
          overflowed_r <= seed_ov_r || sat_now.ov;
          state_r      <= S_RUN;
        end
        S_RUN: begin
          stat_r  <= overflowed_r ? ST_OVF : ST_OK;
          state_r <= missing_r ? S_UA0 : S_SQ0;
        end
        S_SQ0: state_r <= S_SQ1;
        S_SQ1: state_r <= S_SQ2;
        S_SQ2: state_r <= S_UA0;
        S_UA0: begin
          r2_r    <= r2_now;
          state_r <= S_UA1;
        end
        S_UA1: state_r <= S_UA2;
        S_UA2: state_r <= S_UB0;
        S_UB0: begin
          upd_ov_r <= sat_now.ov;
          state_r  <= S_UB1;
        end
        S_UB1: state_r <= S_UB2;
        S_UB2: state_r <= S_FIN;
        S_FIN: begin
          variance_r   <= sat_now.val;
          overflowed_r <= overflowed_r || upd_ov_r || sat_now.ov;
          state_r      <= S_WAIT;
        end
        S_WAIT: begin
          if (res_ready) begin
            sigma_r  <= inv_r ? '0 : sqrt_root;
            status_r <= stat_r;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // an invalid-parameter result never carries a root
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_INVALID) |-> (out_tdata == '0))
    else $error("invalid status with nonzero sigma");

  // an unseeded filter holds a cleared variance and no overflow
  assert property (@(posedge clk) disable iff (!rst_n)
    !seeded_r |-> (variance_r == '0) && !overflowed_r)
    else $error("unseeded state not clear");

  // the block is busy in the cycle after an item is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted back to back");

  // iterative units only run while an item is in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    (sqrt_busy || div_busy) |-> (state_r != S_IDLE))
    else $error("iterative unit busy while idle");

  // the divider runs only for the unconditional variance seed
  assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_DIV))
    else $error("divider busy outside seeding");

endmodule

FILE: test/garch_variance_filter_core_tb.sv
// testbench for the garch variance filter core: directed table, then random items vs predictor
module garch_variance_filter_core_tb;
  import gvf_pkg::*;

  localparam logic [63:0] VAR_MAX     = 64'(VMAX);
  localparam logic [63:0] SIGMA_TOP   = (64'd1 << SIGMA_W) - 64'd1;
  localparam logic [47:0] ONE_VAR     = 48'h0001_0000_0000;
  localparam int          ITEM_TARGET = 1150;
  localparam int          QUIET_FROM  = 1000;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [63:0] wdata;
    logic [31:0] ret;
    logic        missing;
    logic        restart;
    logic        typed;
    logic [23:0] sigma;
    logic [1:0]  status;
  } row_t;

  typedef struct packed {
    logic [SIGMA_W-1:0] sigma;
    logic [STAT_W-1:0]  status;
  } sigma_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [RET_W-1:0]     in_tdata;    // return_value
  logic [1:0]           in_tuser;    // missing, restart
  logic                 out_tvalid;
  logic                 out_tready;
  logic [SIGMA_W-1:0]   out_tdata;   // sigma
  logic [STAT_W-1:0]    out_tuser;   // status
  logic                 cfg_psel;
  logic                 cfg_penable;
  logic                 cfg_pwrite;
  logic [CFG_AW-1:0]    cfg_paddr;
  logic [CFG_DW-1:0]    cfg_pwdata;
  logic [CFG_DW-1:0]    cfg_prdata;
  logic                 cfg_pready;

  logic [47:0] omega_w   = '0;
  logic [15:0] alpha_w   = '0;
  logic [15:0] beta_w    = '0;
  logic        smode_w   = 1'b0;
  logic [47:0] seedvar_w = '0;
  logic [63:0] cond_var  = '0;
  logic        var_ovf   = 1'b0;
  logic        var_seeded = 1'b0;

  sigma_result_t pending_sigma[$];
  row_t          rows[$];
  int            mismatches = 0;
  int            items_sent = 0;
  logic          quiet      = 1'b0;
  logic          drv_typed  = 1'b0;
  logic [23:0]   drv_sigma  = '0;
  logic [1:0]    drv_status = '0;

  garch_variance_filter_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] weight_mul(input logic [63:0] x, input logic [63:0] w);
    return (x >> 16) * w + (((x & 64'hFFFF) * w) >> 16);
  endfunction

  // bit 64 flags saturation
  function automatic logic [64:0] clamp_add(input logic [63:0] a, input logic [63:0] b);
    if (a > VAR_MAX || b > VAR_MAX || a > VAR_MAX - b) return {1'b1, VAR_MAX};
    return {1'b0, a + b};
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] rem;
    logic [63:0] bit_w;
    root  = '0;
    rem   = v;
    bit_w = 64'd1 << 62;
    while (bit_w > rem) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (rem >= root + bit_w) begin
        rem  = rem - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  function automatic sigma_result_t garch_advance(input logic [31:0] ret, input logic missing,
                                                  input logic restart);
    logic [63:0]   ab;
    logic [63:0]   bc;
    logic [63:0]   d;
    logic [63:0]   q;
    logic [63:0]   r;
    logic [63:0]   mag;
    logic [63:0]   r2;
    logic [63:0]   sq;
    logic [64:0]   acc;
    logic          ov;
    sigma_result_t res;
    ab = 64'(alpha_w) + 64'(beta_w);
    if (omega_w == 0 || ab >= 64'(MAX_PERSIST) || (smode_w && seedvar_w == 0)) begin
      cond_var   = '0;
      var_seeded = 1'b0;
      var_ovf    = 1'b0;
      res.sigma  = '0;
      res.status = ST_INVALID;
      return res;
    end
    if (restart || !var_seeded) begin
      ov = 1'b0;
      if (smode_w) begin
        acc = {1'b0, 16'd0, seedvar_w};
      end else begin
        bc = 64'(seedvar_w);
        // zero backcast means the unconditional variance
        if (bc == 0) begin
          d  = 64'd65536 - ab;
          q  = 64'(omega_w) / d;
          r  = 64'(omega_w) % d;
          bc = (q << 16) + ((r << 16) / d);
        end
        if (bc > VAR_MAX) begin
          bc = VAR_MAX;
          ov = 1'b1;
        end
        acc = clamp_add(64'(omega_w), weight_mul(bc, ab));
      end
      cond_var   = acc[63:0];
      var_ovf    = ov | acc[64];
      var_seeded = 1'b1;
    end
    sq         = floor_sqrt(cond_var);
    res.sigma  = (sq > SIGMA_TOP) ? SIGMA_TOP[SIGMA_W-1:0] : sq[SIGMA_W-1:0];
    res.status = var_ovf ? ST_OVF : ST_OK;
    if (missing) begin
      r2 = cond_var;
    end else begin
      mag = {32'd0, ret[31] ? (~ret + 32'd1) : ret};
      r2  = (mag * mag) >> 16;
      if (r2 > VAR_MAX) r2 = VAR_MAX;
    end
    acc      = clamp_add(64'(omega_w), weight_mul(r2, 64'(alpha_w)));
    ov       = acc[64];
    acc      = clamp_add(acc[63:0], weight_mul(cond_var, 64'(beta_w)));
    cond_var = acc[63:0];
    if (ov | acc[64]) var_ovf = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin : result_check
    sigma_result_t got;
    sigma_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.sigma  = out_tdata;
        got.status = out_tuser;
        if (pending_sigma.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: sigma %0d status %0d", got.sigma, got.status);
        end else begin
          want = pending_sigma.pop_front();
          if (got.sigma !== want.sigma || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected sigma %0d status %0d, got sigma %0d status %0d",
                       want.sigma, want.status, got.sigma, got.status);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = garch_advance(in_tdata, in_tuser[0], in_tuser[1]);
        if (drv_typed) begin
          want.sigma  = drv_sigma;
          want.status = drv_status;
        end
        pending_sigma.push_back(want);
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[5:3])
          REG_OMEGA:     omega_w   = cfg_pwdata[47:0];
          REG_ALPHA:     alpha_w   = cfg_pwdata[15:0];
          REG_BETA:      beta_w    = cfg_pwdata[15:0];
          REG_SEED_MODE: smode_w   = cfg_pwdata[0];
          REG_SEED_VAR:  seedvar_w = cfg_pwdata[47:0];
          default: ;
        endcase
      end
    end
  end

  task automatic push_item(input logic [31:0] ret, input logic missing, input logic restart,
                           input logic typed, input logic [23:0] sig, input logic [1:0] st);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tdata   = ret;
    in_tuser   = {restart, missing};
    drv_typed  = typed;
    drv_sigma  = sig;
    drv_status = st;
    in_tvalid  = 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_sigma.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 3'b000};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic add_cfg(input logic [2:0] idx, input logic [63:0] value);
    row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.wdata   = value;
    rows.push_back(row);
  endtask

  task automatic add_item(input logic [31:0] ret, input logic missing, input logic restart,
                          input logic typed, input logic [23:0] sig, input logic [1:0] st);
    row_t row;
    row         = '0;
    row.kind    = ROW_ITEM;
    row.ret     = ret;
    row.missing = missing;
    row.restart = restart;
    row.typed   = typed;
    row.sigma   = sig;
    row.status  = st;
    rows.push_back(row);
  endtask

  initial begin : result_sink
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_tready = 1'b1;
      repeat ($urandom_range(0, 40)) @(negedge clk);
    end
  end

  initial begin : stimulus
    logic signed [31:0] rv;
    logic [47:0]        om;
    logic [47:0]        sv;
    logic [15:0]        al;
    logic [15:0]        be;
    logic               md;
    logic               params_ok;
    int                 n;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;

    // registers still at reset values
    add_item(32'h0, 1'b0, 1'b0, 1'b1, 24'd0, ST_INVALID);
    add_cfg(REG_OMEGA, 64'(ONE_VAR));
    add_cfg(REG_ALPHA, 64'd0);
    add_cfg(REG_BETA, 64'd0);
    add_cfg(REG_SEED_MODE, 64'd1);
    add_cfg(REG_SEED_VAR, 64'(ONE_VAR));
    add_item(32'h0, 1'b0, 1'b0, 1'b1, 24'd65536, ST_OK);
    add_item(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 24'd65536, ST_OK);
    add_item(32'h8000_0000, 1'b1, 1'b0, 1'b1, 24'd65536, ST_OK);
    add_item(32'h8000_0000, 1'b0, 1'b1, 1'b1, 24'd65536, ST_OK);
    // direct seed of zero
    add_cfg(REG_SEED_VAR, 64'd0);
    add_item(32'h0000_1000, 1'b0, 1'b0, 1'b1, 24'd0, ST_INVALID);
    // persistence at the limit
    add_cfg(REG_SEED_VAR, 64'(ONE_VAR));
    add_cfg(REG_ALPHA, 64'(MAX_PERSIST));
    add_item(32'h0000_1000, 1'b0, 1'b0, 1'b1, 24'd0, ST_INVALID);
    add_cfg(REG_ALPHA, 64'(MAX_PERSIST) - 64'd1);
    add_item(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, '0, '0);
    add_item(32'h8000_0000, 1'b0, 1'b0, 1'b0, '0, '0);
    add_item(32'h0123_4567, 1'b1, 1'b0, 1'b0, '0, '0);
    // unconditional variance from a zero backcast
    add_cfg(REG_ALPHA, 64'd0);
    add_cfg(REG_BETA, 64'(MAX_PERSIST) - 64'd1);
    add_cfg(REG_SEED_MODE, 64'd0);
    add_cfg(REG_SEED_VAR, 64'd0);
    add_item(32'hFFFF_0000, 1'b0, 1'b1, 1'b0, '0, '0);
    add_item(32'h0004_0000, 1'b1, 1'b0, 1'b0, '0, '0);
    add_item(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, '0, '0);
    // saturated seed
    add_cfg(REG_OMEGA, 64'(VMAX));
    add_item(32'h0000_0001, 1'b0, 1'b1, 1'b1, 24'hFF_FFFF, ST_OVF);
    add_item(32'h8000_0001, 1'b0, 1'b0, 1'b0, '0, '0);
    // typical weights, widest backcast
    add_cfg(REG_OMEGA, 64'd1);
    add_cfg(REG_ALPHA, 64'd6554);
    add_cfg(REG_BETA, 64'd52429);
    add_cfg(REG_SEED_VAR, 64'(VMAX));
    add_item(32'h0002_8F5C, 1'b0, 1'b1, 1'b0, '0, '0);
    add_item(32'hFFFD_70A4, 1'b0, 1'b0, 1'b0, '0, '0);
    add_item(32'h0000_0000, 1'b0, 1'b0, 1'b0, '0, '0);
    add_item(32'h0005_1EB8, 1'b1, 1'b0, 1'b0, '0, '0);
    add_item(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, '0, '0);
    add_cfg(REG_SEED_MODE, 64'd1);
    add_item(32'h0000_0000, 1'b0, 1'b1, 1'b1, 24'hFF_FFFF, ST_OK);
    add_item(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, '0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < rows.size(); i++) begin
      if (rows[i].kind == ROW_CFG) begin
        wait_drained();
        cfg_write(rows[i].reg_idx, rows[i].wdata);
      end else begin
        push_item(rows[i].ret, rows[i].missing, rows[i].restart, rows[i].typed,
                  rows[i].sigma, rows[i].status);
      end
    end

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 11))
        0:       om = VMAX;
        1:       om = 48'd1;
        2:       om = '0;
        default: om = 48'({$urandom, $urandom}) >> $urandom_range(0, 40);
      endcase
      if ($urandom_range(0, 9) == 0) begin
        al = 16'($urandom);
        be = 16'($urandom);
      end else begin
        al = 16'($urandom_range(0, 20000));
        be = 16'($urandom_range(0, int'(MAX_PERSIST) - 1 - int'(al)));
      end
      md = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0:       sv = '0;
        1:       sv = VMAX;
        default: sv = 48'({$urandom, $urandom}) >> $urandom_range(0, 40);
      endcase
      params_ok = (om != 0) && ({1'b0, al} + {1'b0, be} < MAX_PERSIST) && !(md && sv == 0);
      wait_drained();
      cfg_write(REG_OMEGA, 64'(om));
      cfg_write(REG_ALPHA, 64'(al));
      cfg_write(REG_BETA, 64'(be));
      cfg_write(REG_SEED_MODE, 64'(md));
      cfg_write(REG_SEED_VAR, 64'(sv));
      n = params_ok ? $urandom_range(40, 110) : $urandom_range(2, 6);
      repeat (n) begin
        if (items_sent >= QUIET_FROM) quiet = 1'b1;
        rv = $urandom;
        rv = rv >>> (($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(10, 20));
        push_item(rv, $urandom_range(0, 9) == 0, $urandom_range(0, 19) == 0,
                  1'b0, '0, '0);
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("garch_variance_filter_core test passed");
    end else begin
      $display("garch_variance_filter_core test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("garch_variance_filter_core test failed");
    $finish;
  end

endmodule
